// ===== sv/mfs_pkg.sv =====
// Shared types, codes and sizing helpers for the max-frequency stack.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mfs_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int LEVEL_OUT_W  = 7;
    localparam int STATUS_W     = 2;
    localparam int FANIN        = 4;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic load;   // write the broadcast value and level
        logic shift;  // take the content of the cell above
    } cell_ctrl_t;

    // Levels of a 4-ary tree that covers cap leaves.
    function automatic int tree_levels(input int cap);
        int lv;
        lv = ($clog2(cap) + 1) / 2;
        if (lv < 1) begin
            lv = 1;
        end
        return lv;
    endfunction

endpackage

// ===== sv/max_frequency_stack_unit.sv =====
// Top level of the max-frequency stack: cell row, reduction tree, control.
// Depends on mfs_pkg, mfs_cell and mfs_node.
`timescale 1ns / 1ps

// Usage
//   Input beats arrive on s_axis_*: tuser[0] is the opcode (0 push, 1 pop),
//   tdata is the signed value to push (ignored on a pop). Every input beat
//   produces exactly one result beat on m_axis_*: tdata[31:0] is the popped
//   value, tdata[38:32] its level, tuser[1:0] the status (push stored, pop
//   done, pop on empty, push refused because full).
//   Entries sit in a row of CAPACITY cells in insertion order. A 4-ary tree
//   of registered nodes, L = ceil(log4(CAPACITY)) levels deep (3 at 64),
//   reduces the row to a match count (push) or the highest level with the
//   latest tie (pop). The cells then load or shift down in the apply step.
//   Timing: the result beat is registered in the apply step, after the tree
//   has reduced the row. One beat is worked on at a time; s_axis_tready
//   returns high with the result, so the time per item is set by the depth
//   of the reduction tree.
//   Reset: aresetn low empties the row and drops any pending result beat.
//   Stall: a result waits in the output register while m_axis_tready is low;
//   the next input beat may be taken meanwhile, and its own result holds in
//   the apply step until the output register frees up.

module max_frequency_stack_unit #(
    parameter int CAPACITY = mfs_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] popped_value, [38:32] popped_level, [39] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int VW     = mfs_pkg::VALUE_W;
    localparam int LOW    = mfs_pkg::LEVEL_OUT_W;
    localparam int LW     = $clog2(CAPACITY + 1);
    localparam int IW     = $clog2(CAPACITY);
    localparam int LVLS   = mfs_pkg::tree_levels(CAPACITY);
    localparam int NL     = 1 << (2 * LVLS);          // padded leaf count
    localparam int NI     = (NL - 1) / 3;             // internal nodes
    localparam int NT     = NI + NL;
    localparam int SCW    = $clog2(LVLS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [SCW-1:0]        scan_reg, scan_next;
    mfs_pkg::op_t          op_reg;
    logic signed [VW-1:0]  key_reg;
    logic [LW-1:0]         fill_reg, fill_next;

    logic                  m_valid_reg, m_valid_next;
    logic [VW-1:0]         m_val_reg, m_val_next;
    logic [LOW-1:0]        m_lvl_reg, m_lvl_next;
    mfs_pkg::status_t      m_st_reg, m_st_next;

    // tree storage: internal nodes first (heap order), leaves after them
    logic [LW-1:0]         t_cnt [NT];
    logic [LW-1:0]         t_lvl [NT];
    logic [IW-1:0]         t_idx [NT];
    logic [VW-1:0]         t_val [NT];

    logic [VW-1:0]         c_val [CAPACITY];
    logic [LW-1:0]         c_lvl [CAPACITY];
    logic                  c_vld [CAPACITY];
    logic                  c_match [CAPACITY];
    mfs_pkg::cell_ctrl_t   c_ctrl [CAPACITY];

    logic                  accept;
    logic                  out_free;
    logic                  apply_fire;
    logic                  empty;
    logic                  full;
    logic                  do_push;
    logic                  do_pop;
    logic [LW-1:0]         new_lvl;
    logic [LW+LOW-1:0]     lvl_ext;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign apply_fire    = (state_reg == S_APPLY) && out_free;
    assign empty         = (fill_reg == '0);
    assign full          = (fill_reg == LW'(CAPACITY));
    assign do_push       = apply_fire && (op_reg == mfs_pkg::OP_PUSH) && !full;
    assign do_pop        = apply_fire && (op_reg == mfs_pkg::OP_POP) && !empty;
    // root count is below CAPACITY on a push that fits, so level stays in range
    assign new_lvl       = t_cnt[0] + LW'(1);
    assign lvl_ext       = (LW+LOW)'(t_lvl[0]);

    // ---------------- cell row ----------------
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        always_comb begin
            c_ctrl[j].load  = do_push && (fill_reg == LW'(j));
            // drop the popped entry: it and everything above move down one
            c_ctrl[j].shift = do_pop && (t_idx[0] <= IW'(j));
        end

        if (j + 1 < CAPACITY) begin : g_mid
            mfs_cell #(.LVL_W(LW)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (c_ctrl[j]),
                .key_i      (key_reg),
                .load_lvl_i (new_lvl),
                .up_val_i   (c_val[j+1]),
                .up_lvl_i   (c_lvl[j+1]),
                .up_vld_i   (c_vld[j+1]),
                .val_o      (c_val[j]),
                .lvl_o      (c_lvl[j]),
                .vld_o      (c_vld[j]),
                .match_o    (c_match[j])
            );
        end else begin : g_top
            mfs_cell #(.LVL_W(LW)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (c_ctrl[j]),
                .key_i      (key_reg),
                .load_lvl_i (new_lvl),
                .up_val_i   ('0),
                .up_lvl_i   ('0),
                .up_vld_i   (1'b0),
                .val_o      (c_val[j]),
                .lvl_o      (c_lvl[j]),
                .vld_o      (c_vld[j]),
                .match_o    (c_match[j])
            );
        end
    end

    // ---------------- tree leaves ----------------
    for (genvar j = 0; j < NL; j++) begin : g_leaf
        if (j < CAPACITY) begin : g_used
            assign t_cnt[NI+j] = LW'(c_match[j]);
            assign t_lvl[NI+j] = c_lvl[j];
            assign t_idx[NI+j] = IW'(j);
            assign t_val[NI+j] = c_val[j];
        end else begin : g_pad
            assign t_cnt[NI+j] = '0;
            assign t_lvl[NI+j] = '0;
            assign t_idx[NI+j] = '0;
            assign t_val[NI+j] = '0;
        end
    end

    // ---------------- tree nodes ----------------
    for (genvar n = 0; n < NI; n++) begin : g_node
        mfs_node #(.LVL_W(LW), .IDX_W(IW)) u_node (
            .aclk  (aclk),
            .cnt_i ({t_cnt[4*n+4], t_cnt[4*n+3], t_cnt[4*n+2], t_cnt[4*n+1]}),
            .lvl_i ({t_lvl[4*n+4], t_lvl[4*n+3], t_lvl[4*n+2], t_lvl[4*n+1]}),
            .idx_i ({t_idx[4*n+4], t_idx[4*n+3], t_idx[4*n+2], t_idx[4*n+1]}),
            .val_i ({t_val[4*n+4], t_val[4*n+3], t_val[4*n+2], t_val[4*n+1]}),
            .cnt_o (t_cnt[n]),
            .lvl_o (t_lvl[n]),
            .idx_o (t_idx[n]),
            .val_o (t_val[n])
        );
    end

    // ---------------- control ----------------
    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SCAN;
                    scan_next  = '0;
                end
            end
            S_SCAN: begin
                // hold until the root register carries this beat's answer
                scan_next = scan_reg + SCW'(1);
                if (scan_reg == SCW'(LVLS - 1)) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        if (do_push) begin
            fill_next = fill_reg + LW'(1);
        end else if (do_pop) begin
            fill_next = fill_reg - LW'(1);
        end
    end

    // result beat; the output register advances when free
    always_comb begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_val_next   = m_val_reg;
        m_lvl_next   = m_lvl_reg;
        m_st_next    = m_st_reg;
        if (apply_fire) begin
            m_valid_next = 1'b1;
            m_val_next   = '0;
            m_lvl_next   = '0;
            if (op_reg == mfs_pkg::OP_POP) begin
                if (empty) begin
                    m_st_next = mfs_pkg::ST_EMPTY;
                end else begin
                    m_st_next  = mfs_pkg::ST_POPPED;
                    m_val_next = t_val[0];
                    m_lvl_next = lvl_ext[LOW-1:0];
                end
            end else begin
                m_st_next = full ? mfs_pkg::ST_FULL : mfs_pkg::ST_PUSHED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            scan_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= mfs_pkg::op_t'(s_axis_tuser[0]);
            key_reg <= s_axis_tdata;
        end
        m_val_reg <= m_val_next;
        m_lvl_reg <= m_lvl_next;
        m_st_reg  <= m_st_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_lvl_reg, m_val_reg};
    assign m_axis_tuser  = m_st_reg;

endmodule

// ===== sv/mfs_cell.sv =====
// One storage cell of the ordered entry row: value, level, valid.
// Depends on mfs_pkg.
`timescale 1ns / 1ps

module mfs_cell #(
    parameter int LVL_W = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mfs_pkg::cell_ctrl_t            ctrl,
    input  logic [mfs_pkg::VALUE_W-1:0]    key_i,
    input  logic [LVL_W-1:0]               load_lvl_i,
    input  logic [mfs_pkg::VALUE_W-1:0]    up_val_i,
    input  logic [LVL_W-1:0]               up_lvl_i,
    input  logic                           up_vld_i,
    output logic [mfs_pkg::VALUE_W-1:0]    val_o,
    output logic [LVL_W-1:0]               lvl_o,
    output logic                           vld_o,
    output logic                           match_o
);

    logic                          vld_reg;
    logic [mfs_pkg::VALUE_W-1:0]   val_reg;
    logic [LVL_W-1:0]              lvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ctrl.load) begin
            vld_reg <= 1'b1;
        end else if (ctrl.shift) begin
            vld_reg <= up_vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            val_reg <= key_i;
            lvl_reg <= load_lvl_i;
        end else if (ctrl.shift) begin
            val_reg <= up_val_i;
            lvl_reg <= up_lvl_i;
        end
    end

    // An empty cell shows level zero and never matches.
    assign val_o   = val_reg;
    assign lvl_o   = vld_reg ? lvl_reg : '0;
    assign vld_o   = vld_reg;
    assign match_o = vld_reg && (val_reg == key_i);

endmodule

// ===== sv/mfs_node.sv =====
// Registered 4-input node of the reduction tree: match count sum and
// highest level (later child wins ties) with its index and value. Uses mfs_pkg.
`timescale 1ns / 1ps

module mfs_node #(
    parameter int LVL_W = 7,
    parameter int IDX_W = 6
) (
    input  logic                                         aclk,
    input  logic [mfs_pkg::FANIN-1:0][LVL_W-1:0]         cnt_i,
    input  logic [mfs_pkg::FANIN-1:0][LVL_W-1:0]         lvl_i,
    input  logic [mfs_pkg::FANIN-1:0][IDX_W-1:0]         idx_i,
    input  logic [mfs_pkg::FANIN-1:0][mfs_pkg::VALUE_W-1:0] val_i,
    output logic [LVL_W-1:0]                             cnt_o,
    output logic [LVL_W-1:0]                             lvl_o,
    output logic [IDX_W-1:0]                             idx_o,
    output logic [mfs_pkg::VALUE_W-1:0]                  val_o
);

    logic [LVL_W+1:0]              sum;
    logic [LVL_W-1:0]              cnt_next, cnt_reg;
    logic [LVL_W-1:0]              lvl_next, lvl_reg;
    logic [IDX_W-1:0]              idx_next, idx_reg;
    logic [mfs_pkg::VALUE_W-1:0]   val_next, val_reg;

    always_comb begin
        sum = '0;
        for (int j = 0; j < mfs_pkg::FANIN; j++) begin
            sum = sum + (LVL_W+2)'(cnt_i[j]);
        end
        // total never exceeds the row size, so the narrow count is exact
        cnt_next = sum[LVL_W-1:0];
        lvl_next = lvl_i[0];
        idx_next = idx_i[0];
        val_next = val_i[0];
        for (int j = 1; j < mfs_pkg::FANIN; j++) begin
            if (lvl_i[j] >= lvl_next) begin
                lvl_next = lvl_i[j];
                idx_next = idx_i[j];
                val_next = val_i[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        lvl_reg <= lvl_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

    assign cnt_o = cnt_reg;
    assign lvl_o = lvl_reg;
    assign idx_o = idx_reg;
    assign val_o = val_reg;

endmodule

// ===== sv/mfs_checker.sv =====
// Port-level checker for max_frequency_stack_unit and its bind.
// Depends on mfs_pkg; sees only the top level's ports.
`timescale 1ns / 1ps

module mfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // one beat in work at a time: ready drops after each accepted beat
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a beat is in work");

    // only a successful pop carries data
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != 2'(mfs_pkg::ST_POPPED)) |->
            m_axis_tdata == '0)
        else $error("non-pop result carries data");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind max_frequency_stack_unit mfs_checker u_mfs_checker (.*);
